### hdl/mmp_pkg.sv
// Shared types and constants for the mouse motion packetizer.
package mmp_pkg;

  // Configuration register indexes.
  localparam logic REG_MOUSE_FORMAT = 1'b0;
  localparam logic REG_SERIAL_PORT  = 1'b1;

  // Mouse format codes.
  localparam logic [1:0] FMT_NONE   = 2'd0;
  localparam logic [1:0] FMT_PS2    = 2'd1;
  localparam logic [1:0] FMT_SERIAL = 2'd2;

  // Per-packet chunk limits.
  localparam logic signed [7:0] X_MIN = -8'sd128;
  localparam logic signed [7:0] X_MAX = 8'sd127;
  localparam logic signed [7:0] Y_MIN = -8'sd127;
  localparam logic signed [7:0] Y_MAX = 8'sd127;

  // Packet cap per event.
  localparam int MAX_PACKETS = 33;
  localparam int CNT_W       = 6;

  // Status byte bit masks.
  localparam logic [7:0] PS2_ALWAYS   = 8'h08;
  localparam logic [7:0] PS2_X_SIGN   = 8'h10;
  localparam logic [7:0] PS2_Y_SIGN   = 8'h20;
  localparam logic [7:0] SER_SYNC     = 8'h40;
  localparam logic [7:0] SER_LEFT     = 8'h20;
  localparam logic [7:0] SER_RIGHT    = 8'h10;
  localparam logic [7:0] SER_X_SIGN   = 8'h02;
  localparam logic [7:0] SER_Y_SIGN   = 8'h08;
  localparam logic [7:0] SER_X_BIT6   = 8'h01;
  localparam logic [7:0] SER_Y_BIT6   = 8'h04;
  localparam logic [7:0] SER_LOW_MASK = 8'h3f;

  // One chunk taken from the remainders.
  typedef struct packed {
    logic signed [7:0] cx;
    logic signed [7:0] cy;
    logic              rest_zero;
  } chunk_t;

  // Formatted packet bytes.
  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } packet_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

endpackage

### hdl/mouse_motion_packetizer.sv
// Top level of the mouse motion packetizer: sequencer, config and output register.
//
// One input word carries signed X and Y deltas and a button status byte.
// The block cuts the motion into three-byte packets, one output word per
// packet, and marks the final packet with out_last_packet. Each packet
// takes one step of the shared clamp and subtract unit, which is loaded
// when the input word is accepted; an event has N packets (1 to 33), and
// each packet is registered in the output register before it appears.
// N is the number of clamped steps it takes to empty the larger remainder
// (127 per step, 128 for a negative X step), at least one and at most 33.
// in_stall is high while an event is being cut; it drops as soon as the
// final packet is in the output register, even if that packet still waits.
// While out_valid is high, out_stall pauses the sequencer and holds the word.
// The config port (cfg_index 0: mouse format, 1: serial port present) is
// always ready. The user must write it only while the block is idle; the
// block does not enforce this. With no mouse format (code 0 or 3), or
// serial format without a port, an input word is taken and yields no output.
// Reset (rst_n low, synchronous) clears both config registers, empties the
// output register and returns the sequencer to idle.
module mouse_motion_packetizer #(
  parameter int DELTA_WIDTH = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DELTA_WIDTH-1:0] in_delta_x,
  input  logic signed [DELTA_WIDTH-1:0] in_delta_y,
  input  logic [7:0]                    in_button_status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_status_byte,
  output logic [7:0]                    out_x_byte,
  output logic [7:0]                    out_y_byte,
  output logic                          out_last_packet,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [1:0]                    cfg_data
);
  import mmp_pkg::*;

  state_t           state_r, state_nxt;
  logic [1:0]       fmt_r;
  logic             port_r;
  logic             ps2_r;
  logic [7:0]       btn_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  packet_t          out_pkt_r;
  logic             out_last_r;

  logic    in_take, enabled, is_ps2, out_free, fire, last;
  chunk_t  chunk;
  packet_t pkt;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_NONE;
      port_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MOUSE_FORMAT: fmt_r  <= cfg_data;
        REG_SERIAL_PORT:  port_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake and sequencing.
  assign is_ps2   = (fmt_r == FMT_PS2);
  assign enabled  = is_ps2 || ((fmt_r == FMT_SERIAL) && port_r);
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == ST_RUN) && out_free;
  assign last     = chunk.rest_zero || (cnt_r == CNT_W'(MAX_PACKETS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_take && enabled) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (fire) begin
          cnt_nxt = cnt_r + 1'b1;
          if (last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-event context.
  always_ff @(posedge clk) begin
    if (in_take) begin
      ps2_r <= is_ps2;
      btn_r <= in_button_status;
    end
  end

  mmp_chunk_unit #(
    .DELTA_WIDTH(DELTA_WIDTH)
  ) u_chunk (
    .clk   (clk),
    .load  (in_take),
    .step  (fire),
    .load_x(in_delta_x),
    .load_y(in_delta_y),
    .chunk (chunk)
  );

  mmp_pkt_fmt u_fmt (
    .ps2_mode     (ps2_r),
    .button_status(btn_r),
    .chunk        (chunk),
    .pkt          (pkt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_pkt_r  <= pkt;
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_byte = out_pkt_r.status_byte;
  assign out_x_byte      = out_pkt_r.x_byte;
  assign out_y_byte      = out_pkt_r.y_byte;
  assign out_last_packet = out_last_r;

endmodule

### hdl/mmp_chunk_unit.sv
// Remainder registers with the shared clamp and subtract unit.
module mmp_chunk_unit #(
  parameter int DELTA_WIDTH = 13
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic signed [DELTA_WIDTH-1:0] load_x,
  input  logic signed [DELTA_WIDTH-1:0] load_y,
  output mmp_pkg::chunk_t               chunk
);
  import mmp_pkg::*;

  localparam logic signed [DELTA_WIDTH-1:0] LO_X = DELTA_WIDTH'(X_MIN);
  localparam logic signed [DELTA_WIDTH-1:0] HI_X = DELTA_WIDTH'(X_MAX);
  localparam logic signed [DELTA_WIDTH-1:0] LO_Y = DELTA_WIDTH'(Y_MIN);
  localparam logic signed [DELTA_WIDTH-1:0] HI_Y = DELTA_WIDTH'(Y_MAX);

  logic signed [DELTA_WIDTH-1:0] rx_r, rx_nxt;
  logic signed [DELTA_WIDTH-1:0] ry_r, ry_nxt;
  logic signed [7:0]             cx, cy;

  // Clamp the remainders to one packet's range.
  always_comb begin
    if (rx_r < LO_X) begin
      cx = X_MIN;
    end else if (rx_r > HI_X) begin
      cx = X_MAX;
    end else begin
      cx = rx_r[7:0];
    end
    if (ry_r < LO_Y) begin
      cy = Y_MIN;
    end else if (ry_r > HI_Y) begin
      cy = Y_MAX;
    end else begin
      cy = ry_r[7:0];
    end
  end

  // Take the chunk off what remains.
  assign rx_nxt = rx_r - DELTA_WIDTH'(cx);
  assign ry_nxt = ry_r - DELTA_WIDTH'(cy);

  assign chunk.cx        = cx;
  assign chunk.cy        = cy;
  assign chunk.rest_zero = (rx_nxt == '0) && (ry_nxt == '0);

  always_ff @(posedge clk) begin
    if (load) begin
      rx_r <= load_x;
      ry_r <= load_y;
    end else if (step) begin
      rx_r <= rx_nxt;
      ry_r <= ry_nxt;
    end
  end

endmodule

### hdl/mmp_pkt_fmt.sv
// Packet byte formatting for the PS/2 and serial mouse layouts.
module mmp_pkt_fmt (
  input  logic             ps2_mode,
  input  logic [7:0]       button_status,
  input  mmp_pkg::chunk_t  chunk,
  output mmp_pkg::packet_t pkt
);
  import mmp_pkg::*;

  logic signed [7:0] ny;
  logic [7:0]        xb, yb, st;

  always_comb begin
    ny = -chunk.cy;
    xb = chunk.cx;
    yb = chunk.cy;
    if (ps2_mode) begin
      // PS/2 reports Y upward, so the chunk is negated.
      yb = ny;
      st = button_status | PS2_ALWAYS;
      if (chunk.cx[7]) st = st | PS2_X_SIGN;
      if (ny[7]) st = st | PS2_Y_SIGN;
    end else begin
      // Serial layout moves bit 6 of each delta into the status byte.
      st = SER_SYNC;
      if (button_status[0]) st = st | SER_LEFT;
      if (button_status[1]) st = st | SER_RIGHT;
      if (chunk.cx[7]) st = st | SER_X_SIGN;
      if (chunk.cy[7]) st = st | SER_Y_SIGN;
      if (xb[6]) begin
        st = st | SER_X_BIT6;
        xb = xb & SER_LOW_MASK;
      end
      if (yb[6]) begin
        st = st | SER_Y_BIT6;
        yb = yb & SER_LOW_MASK;
      end
    end
    pkt.status_byte = st;
    pkt.x_byte      = xb;
    pkt.y_byte      = yb;
  end

endmodule

### bench/mmp_checker.sv
// Checker for the mouse motion packetizer: predicts every packet word and compares the output.
module motion_packet_checker #(
  parameter int DELTA_WIDTH = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [DELTA_WIDTH-1:0] in_delta_x,
  input  logic signed [DELTA_WIDTH-1:0] in_delta_y,
  input  logic [7:0]                    in_button_status,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    out_status_byte,
  input  logic [7:0]                    out_x_byte,
  input  logic [7:0]                    out_y_byte,
  input  logic                          out_last_packet,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [1:0]                    cfg_data,
  output int                            fail_count,
  output int                            packets_owed
);
  import mmp_pkg::*;

  // One packet as it should leave the block.
  typedef struct {
    logic [7:0] status_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    logic       last_packet;
  } packet_word_t;

  packet_word_t owed_q[$];
  packet_word_t got;
  logic [1:0]   fmt_mirror  = FMT_NONE;
  logic         port_mirror = 1'b0;
  int           errors      = 0;

  function automatic int clamp_chunk(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Cut one motion event into packets under the current mouse format.
  function automatic void cut_motion(input logic signed [DELTA_WIDTH-1:0] dx,
                                     input logic signed [DELTA_WIDTH-1:0] dy,
                                     input logic [7:0] btn);
    int           rx;
    int           ry;
    int           cx;
    int           cy;
    int           ny;
    int           n;
    logic         ps2;
    packet_word_t w;
    if (fmt_mirror == FMT_PS2) begin
      ps2 = 1'b1;
    end else if (fmt_mirror == FMT_SERIAL && port_mirror) begin
      ps2 = 1'b0;
    end else begin
      return;
    end
    rx = int'(dx);
    ry = int'(dy);
    n  = 0;
    do begin
      cx = clamp_chunk(rx, int'(X_MIN), int'(X_MAX));
      cy = clamp_chunk(ry, int'(Y_MIN), int'(Y_MAX));
      rx -= cx;
      ry -= cy;
      w.last_packet = (rx == 0 && ry == 0) || (n + 1 >= MAX_PACKETS);
      w.x_byte = cx[7:0];
      if (ps2) begin
        ny = -cy;
        w.y_byte = ny[7:0];
        w.status_byte = btn | PS2_ALWAYS;
        if (cx < 0) w.status_byte |= PS2_X_SIGN;
        if (ny < 0) w.status_byte |= PS2_Y_SIGN;
      end else begin
        w.y_byte = cy[7:0];
        w.status_byte = SER_SYNC;
        if (btn[0]) w.status_byte |= SER_LEFT;
        if (btn[1]) w.status_byte |= SER_RIGHT;
        if (cx < 0) w.status_byte |= SER_X_SIGN;
        if (cy < 0) w.status_byte |= SER_Y_SIGN;
        // Serial bytes carry bit 6 of each chunk in the status byte.
        if (w.x_byte[6]) begin
          w.status_byte |= SER_X_BIT6;
          w.x_byte &= SER_LOW_MASK;
        end
        if (w.y_byte[6]) begin
          w.status_byte |= SER_Y_BIT6;
          w.y_byte &= SER_LOW_MASK;
        end
      end
      owed_q.push_back(w);
      n++;
    end while (!w.last_packet);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected %h, got %h", name, want, seen);
      errors++;
    end
  endfunction

  // Output words are checked before new predictions join the queue.
  always @(posedge clk) begin
    if (!rst_n) begin
      fmt_mirror  = FMT_NONE;
      port_mirror = 1'b0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected packet word: status %h x %h y %h last %b",
                 out_status_byte, out_x_byte, out_y_byte, out_last_packet);
          errors++;
        end else begin
          got = owed_q.pop_front();
          check_field("status_byte", got.status_byte, out_status_byte);
          check_field("x_byte", got.x_byte, out_x_byte);
          check_field("y_byte", got.y_byte, out_y_byte);
          check_field("last_packet", {7'd0, got.last_packet}, {7'd0, out_last_packet});
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MOUSE_FORMAT) begin
          fmt_mirror = cfg_data;
        end else begin
          port_mirror = cfg_data[0];
        end
      end
      if (in_valid && !in_stall) begin
        cut_motion(in_delta_x, in_delta_y, in_button_status);
      end
    end
    fail_count   <= errors;
    packets_owed <= owed_q.size();
  end

endmodule

### bench/tb_top.sv
// Testbench top for the mouse motion packetizer: clock, reset, stimulus and verdict.
module tb_top;
  import mmp_pkg::*;

  localparam int DELTA_W       = 13;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CAP     = 20000;
  localparam int TARGET_WORDS  = 220;
  localparam int CALM_AFTER    = 185;

  // The format code left unused by the block.
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  // Serial port register values; the upper data bit is ignored by the block.
  localparam logic [1:0] PORT_OFF    = 2'b00;
  localparam logic [1:0] PORT_ON     = 2'b01;
  localparam logic [1:0] PORT_OFF_HI = 2'b10;
  localparam logic [1:0] PORT_ON_HI  = 2'b11;

  localparam int CORNER[11] = '{0, 127, -127, 128, -128, 64, -64, 63, -65, 4095, -4096};

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [DELTA_W-1:0] in_delta_x;
  logic signed [DELTA_W-1:0] in_delta_y;
  logic [7:0]                in_button_status;
  logic                      out_valid;
  logic                      out_stall;
  logic [7:0]                out_status_byte;
  logic [7:0]                out_x_byte;
  logic [7:0]                out_y_byte;
  logic                      out_last_packet;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_index;
  logic [1:0]                cfg_data;
  int                        fail_count;
  int                        packets_owed;

  bit calm       = 1'b0;
  bit hold_req   = 1'b0;
  bit mode_emits = 1'b0;
  int gap_pct    = 0;
  int useful     = 0;

  mouse_motion_packetizer #(.DELTA_WIDTH(DELTA_W)) dut (.*);

  motion_packet_checker #(.DELTA_WIDTH(DELTA_W)) chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver side: random stall bursts, quiet windows, and one long hold on request.
  initial begin
    int hold_left;
    int burst_left;
    int pct;
    int window;
    hold_left  = 0;
    burst_left = 0;
    pct        = 0;
    window     = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        window = 64;
        case ($urandom_range(0, 2))
          0: pct = 0;
          1: pct = 10;
          default: pct = 30;
        endcase
      end
      window--;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < pct) begin
        burst_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one motion word, after an optional gap, and wait until it is taken.
  task automatic send_word(logic signed [DELTA_W-1:0] dx, logic signed [DELTA_W-1:0] dy,
                           logic [7:0] btn);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_delta_x       <= dx;
    in_delta_y       <= dy;
    in_button_status <= btn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mode_emits) useful++;
  endtask

  // Stop offering words and wait until every predicted packet has arrived or the wait cap runs out.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (packets_owed != 0 && waited < DRAIN_CAP);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only once the block has gone idle.
  task automatic set_mode(logic [1:0] fmt, logic [1:0] port);
    drain();
    write_reg(REG_MOUSE_FORMAT, fmt);
    write_reg(REG_SERIAL_PORT, port);
    mode_emits = (fmt == FMT_PS2) || (fmt == FMT_SERIAL && port[0]);
  endtask

  // Mostly small motion, some medium, some full range and some chunk boundaries.
  function automatic logic signed [DELTA_W-1:0] rand_delta();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = $urandom_range(0, 600) - 300;
      6, 7: v = $urandom_range(0, 2000) - 1000;
      8: v = $urandom;
      default: v = CORNER[$urandom_range(0, 10)];
    endcase
    return v[DELTA_W-1:0];
  endfunction

  initial begin
    int phase;
    int len;
    int k;
    logic [1:0] port;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_delta_x       <= '0;
    in_delta_y       <= '0;
    in_button_status <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_MOUSE_FORMAT;
    cfg_data         <= FMT_NONE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // PS/2 format: zero motion, full-scale deltas and clamp boundaries.
    set_mode(FMT_PS2, PORT_OFF);
    send_word(0, 0, 8'h00);
    send_word(4095, 4095, 8'hff);
    send_word(-4096, -4096, 8'h00);
    send_word(127, -127, 8'h03);
    send_word(-128, 127, 8'h05);
    send_word(128, -128, 8'ha0);
    send_word(-129, 128, 8'h5a);
    send_word(1, -1, 8'h01);

    // Serial format with a port: bit 6 folding and sign bits.
    set_mode(FMT_SERIAL, PORT_ON_HI);
    send_word(0, 0, 8'h00);
    send_word(64, -64, 8'h01);
    send_word(63, -65, 8'h02);
    send_word(4095, -4096, 8'h03);
    send_word(-4096, 4095, 8'hfc);
    send_word(127, -127, 8'h00);
    send_word(-128, 127, 8'h01);

    // Serial format without a port, no mouse, and the unused format code.
    set_mode(FMT_SERIAL, PORT_OFF_HI);
    send_word(100, 100, 8'h03);
    send_word(0, 0, 8'h00);
    set_mode(FMT_NONE, PORT_ON);
    send_word(5, 5, 8'h01);
    send_word(-4096, 4095, 8'hff);
    set_mode(FMT_UNUSED, PORT_ON);
    send_word(0, 0, 8'h00);
    send_word(300, -300, 8'h02);

    // Random phases, each under its own register setting and idle density.
    useful = 0;
    phase  = 0;
    while (useful < TARGET_WORDS) begin
      port = 2'($urandom_range(0, 3));
      if (phase == 0) begin
        set_mode(FMT_PS2, port);
      end else begin
        case ($urandom_range(0, 9))
          0: set_mode(FMT_NONE, port);
          1: set_mode(FMT_UNUSED, port);
          2: set_mode(FMT_SERIAL, $urandom_range(0, 1) ? PORT_OFF : PORT_OFF_HI);
          3, 4, 5, 6: set_mode(FMT_PS2, port);
          default: set_mode(FMT_SERIAL, $urandom_range(0, 1) ? PORT_ON : PORT_ON_HI);
        endcase
      end
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 35;
      endcase
      len = mode_emits ? $urandom_range(15, 45) : $urandom_range(3, 8);
      for (k = 0; k < len && useful < TARGET_WORDS; k++) begin
        // The receiver holds off for a long time while words keep coming.
        if (phase == 0 && k == 4) hold_req = 1'b1;
        if (phase == 1 && k == 10) drain();
        send_word(rand_delta(), rand_delta(), 8'($urandom_range(0, 255)));
        calm = (useful >= CALM_AFTER);
      end
      phase++;
    end

    drain();
    if (fail_count == 0 && packets_owed == 0) begin
      $display("Regression PASS");
    end else begin
      if (packets_owed != 0) $error("%0d packet words never arrived", packets_owed);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
